// ----- rtl/core/dix_pkg.sv -----
// Shared types and constants for the divide instruction execute core.
package dix_pkg;

    localparam int OP_W    = 32;
    localparam int IDX_W   = 4;
    localparam int PC_W    = 32;
    localparam int CNT_W   = 32;
    localparam logic [PC_W-1:0] PC_STEP = PC_W'(4);

    // Side information that rides along with each request through the divider
    typedef struct packed {
        logic             mode;
        logic             neg;
        logic             zero_div;
        logic             trap;
        logic [IDX_W-1:0] dest_index;
        logic [PC_W-1:0]  next_pc;
    } side_t;

    // Result payload as held in the output register
    typedef struct packed {
        logic [OP_W-1:0]  quotient;
        logic [IDX_W-1:0] write_index;
        logic             write_enable;
        logic [PC_W-1:0]  next_pc;
        logic             trapped;
        logic [CNT_W-1:0] signed_count;
        logic [CNT_W-1:0] unsigned_count;
    } rsp_t;

endpackage

// ----- rtl/core/dix_if.sv -----
// Request and result channel interfaces of the divide instruction execute core.
interface dix_req_if import dix_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [OP_W-1:0]  dividend;
    logic [OP_W-1:0]  divisor;
    logic [IDX_W-1:0] dest_index;
    logic [PC_W-1:0]  pc;

    modport source (output valid, mode, dividend, divisor, dest_index, pc, input ready);
    modport sink   (input valid, mode, dividend, divisor, dest_index, pc, output ready);
endinterface

interface dix_rsp_if import dix_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  quotient;
    logic [IDX_W-1:0] write_index;
    logic             write_enable;
    logic [PC_W-1:0]  next_pc;
    logic             trapped;
    logic [CNT_W-1:0] signed_count;
    logic [CNT_W-1:0] unsigned_count;

    modport source (output valid, quotient, write_index, write_enable, next_pc, trapped,
                    signed_count, unsigned_count, input ready);
    modport sink   (input valid, quotient, write_index, write_enable, next_pc, trapped,
                    signed_count, unsigned_count, output ready);
endinterface

// ----- rtl/core/divide_instruction_execute_core.sv -----
// Path from request accept to result valid: entry register, the step registers, then the output register.
// Throughput: one request per cycle while no result waits; one restoring step per stage, DATA_WIDTH step stages.
// Back-pressure: the whole pipe holds together while a result waits; nothing is lost.
// Reset (rst_n, async, active low): clears all valid bits, both operation counters and
// the trap-on-zero setting; payload registers are not reset.
// Top level of the divide instruction execute core.
module divide_instruction_execute_core import dix_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    dix_req_if.sink   req,
    dix_rsp_if.source rsp,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data
);

    // Stage 0 is the entry register; stage DATA_WIDTH holds the finished magnitude.
    logic                  st_valid [0:DATA_WIDTH];
    side_t                 st_side  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] st_acc   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] st_rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] st_den   [0:DATA_WIDTH];

    logic advance;
    logic out_valid;
    rsp_t out_rsp;

    // Advance every stage together whenever the output register is free or
    // being drained; hold everything otherwise.
    assign advance   = ~out_valid | rsp.ready;
    assign req.ready = advance;

    // Take magnitudes, settle sign and trap, compute the next pc
    dix_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .valid_in    (req.valid),
        .mode        (req.mode),
        .dividend    (req.dividend),
        .divisor     (req.divisor),
        .dest_index  (req.dest_index),
        .pc          (req.pc),
        .valid_out   (st_valid[0]),
        .side_out    (st_side[0]),
        .acc_out     (st_acc[0]),
        .rem_out     (st_rem[0]),
        .den_out     (st_den[0])
    );

    // One quotient bit per stage, most significant first
    for (genvar g = 0; g < DATA_WIDTH; g++)
    begin : g_step
        dix_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (st_valid[g]),
            .side_in   (st_side[g]),
            .acc_in    (st_acc[g]),
            .rem_in    (st_rem[g]),
            .den_in    (st_den[g]),
            .valid_out (st_valid[g+1]),
            .side_out  (st_side[g+1]),
            .acc_out   (st_acc[g+1]),
            .rem_out   (st_rem[g+1]),
            .den_out   (st_den[g+1])
        );
    end

    // Apply the sign, bump the counters in request order, register the result
    dix_fin #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fin (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (st_valid[DATA_WIDTH]),
        .side_in   (st_side[DATA_WIDTH]),
        .mag_in    (st_acc[DATA_WIDTH]),
        .valid_out (out_valid),
        .rsp_out   (out_rsp)
    );

    assign rsp.valid          = out_valid;
    assign rsp.quotient       = out_rsp.quotient;
    assign rsp.write_index    = out_rsp.write_index;
    assign rsp.write_enable   = out_rsp.write_enable;
    assign rsp.next_pc        = out_rsp.next_pc;
    assign rsp.trapped        = out_rsp.trapped;
    assign rsp.signed_count   = out_rsp.signed_count;
    assign rsp.unsigned_count = out_rsp.unsigned_count;

endmodule

// ----- rtl/core/dix_prep.sv -----
// Entry stage: trap register, operand magnitudes, sign and trap decision, pc update.
module dix_prep import dix_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  valid_in,
    input  logic                  mode,
    input  logic [OP_W-1:0]       dividend,
    input  logic [OP_W-1:0]       divisor,
    input  logic [IDX_W-1:0]      dest_index,
    input  logic [PC_W-1:0]       pc,
    output logic                  valid_out,
    output side_t                 side_out,
    output logic [DATA_WIDTH-1:0] acc_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] den_out
);

    logic                  trap_on_zero_reg;
    logic                  valid_reg;
    side_t                 side_reg;
    side_t                 side_next;
    logic [DATA_WIDTH-1:0] num;
    logic [DATA_WIDTH-1:0] den;
    logic                  num_sign;
    logic                  den_sign;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] acc_next;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] den_next;

    always_comb
    begin
        num      = DATA_WIDTH'(dividend);
        den      = DATA_WIDTH'(divisor);
        num_sign = mode & num[DATA_WIDTH-1];
        den_sign = mode & den[DATA_WIDTH-1];
        acc_next = num_sign ? (~num + 1'b1) : num;
        den_next = den_sign ? (~den + 1'b1) : den;

        side_next.mode       = mode;
        side_next.neg        = num_sign ^ den_sign;
        side_next.zero_div   = (den == '0);
        side_next.trap       = (den == '0) & trap_on_zero_reg;
        side_next.dest_index = dest_index;
        side_next.next_pc    = side_next.trap ? pc : pc + PC_STEP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trap_on_zero_reg <= 1'b0;
            valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                trap_on_zero_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                valid_reg <= valid_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            side_reg <= side_next;
            acc_reg  <= acc_next;
            den_reg  <= den_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign acc_out   = acc_reg;
    assign rem_out   = '0;
    assign den_out   = den_reg;

endmodule

// ----- rtl/core/dix_step.sv -----
// One restoring division step: shift in a dividend bit, trial subtract, record quotient bit.
module dix_step import dix_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  valid_in,
    input  side_t                 side_in,
    input  logic [DATA_WIDTH-1:0] acc_in,
    input  logic [DATA_WIDTH-1:0] rem_in,
    input  logic [DATA_WIDTH-1:0] den_in,
    output logic                  valid_out,
    output side_t                 side_out,
    output logic [DATA_WIDTH-1:0] acc_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] den_out
);

    logic                  valid_reg;
    side_t                 side_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] acc_next;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    // Partial remainder stays below the divisor, so a borrow out of bit
    // DATA_WIDTH marks a trial that does not fit.
    always_comb
    begin
        trial    = {rem_in, acc_in[DATA_WIDTH-1]};
        diff     = trial - {1'b0, den_in};
        fits     = ~diff[DATA_WIDTH];
        rem_next = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        acc_next = {acc_in[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            side_reg <= side_in;
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            den_reg  <= den_in;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign acc_out   = acc_reg;
    assign rem_out   = rem_reg;
    assign den_out   = den_reg;

endmodule

// ----- rtl/core/dix_fin.sv -----
// Exit stage: quotient sign fix-up, operation counters and the output register.
module dix_fin import dix_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  valid_in,
    input  side_t                 side_in,
    input  logic [DATA_WIDTH-1:0] mag_in,
    output logic                  valid_out,
    output rsp_t                  rsp_out
);

    logic                  valid_reg;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    logic [CNT_W-1:0]      scnt_reg;
    logic [CNT_W-1:0]      scnt_next;
    logic [CNT_W-1:0]      ucnt_reg;
    logic [CNT_W-1:0]      ucnt_next;
    logic [DATA_WIDTH-1:0] quo;
    logic                  bump;

    always_comb
    begin
        if (side_in.zero_div)
        begin
            quo = '0;
        end
        else if (side_in.neg)
        begin
            quo = ~mag_in + 1'b1;
        end
        else
        begin
            quo = mag_in;
        end

        bump      = valid_in & ~side_in.trap;
        scnt_next = (bump && side_in.mode)  ? scnt_reg + 1'b1 : scnt_reg;
        ucnt_next = (bump && !side_in.mode) ? ucnt_reg + 1'b1 : ucnt_reg;

        rsp_next.quotient       = OP_W'(quo);
        rsp_next.write_index    = side_in.dest_index;
        rsp_next.write_enable   = ~side_in.trap;
        rsp_next.next_pc        = side_in.next_pc;
        rsp_next.trapped        = side_in.trap;
        rsp_next.signed_count   = scnt_next;
        rsp_next.unsigned_count = ucnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            scnt_reg  <= '0;
            ucnt_reg  <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
            scnt_reg  <= scnt_next;
            ucnt_reg  <= ucnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign valid_out = valid_reg;
    assign rsp_out   = rsp_reg;

endmodule

// ----- rtl/core/dix_chk.sv -----
// Port-level assertion checker for the divide instruction execute core, with its bind.
module dix_chk import dix_pkg::*; (
    input logic            clk,
    input logic            rst_n,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input logic [OP_W-1:0] quotient,
    input logic            write_enable,
    input logic            trapped
);

    // Hold a result until it is taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before it was taken");

    // An empty output register never blocks a new request
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request blocked with output register empty");

    // A trapped divide never writes back
    a_trap_we: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (write_enable != trapped))
        else $error("write enable and trap flag disagree");

    // A trapped divide reports a zero quotient
    a_trap_quo: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && trapped |-> (quotient == '0))
        else $error("trapped result carries a nonzero quotient");

endmodule

bind divide_instruction_execute_core dix_chk u_dix_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .quotient     (rsp.quotient),
    .write_enable (rsp.write_enable),
    .trapped      (rsp.trapped)
);
